@@ rtl/ordered_list_engine_assert.svh @@
// Assertion macros for the checker file of the ordered list engine.
// Depends on nothing; the including module must provide clock and reset.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ole_pkg.sv @@
// Package for the ordered list engine: sizes, operation and status codes,
// and the request and response word types. Depends on nothing.
package ole_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      OP_INS_IDX   = 3'd0,
      OP_INS_FRONT = 3'd1,
      OP_INS_BACK  = 3'd2,
      OP_DEL_IDX   = 3'd3,
      OP_DEL_FRONT = 3'd4,
      OP_DEL_BACK  = 3'd5,
      OP_SEARCH    = 3'd6,
      OP_REVERSE   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_BAD_INDEX = 3'd2,
      ST_FULL      = 3'd3,
      ST_MISS      = 3'd4
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
      logic [6:0]         index;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] removed_value;
      logic [5:0]         found_position;
      logic [6:0]         element_total;
   } rsp_word_type;

endpackage

@@ rtl/ordered_list_engine.sv @@
// Ordered list engine: a bounded sequence of signed values held in a flat
// store and worked on by a small read/write sequencer. Depends on ole_pkg.
//
// Usage. A request word (operation, value, index) is taken at a rising edge
// where start is high and busy is low. The engine then raises busy and walks
// the store through its single write port and registered read ports. When
// the work is finished it shows one response word (status, removed value,
// found position, element count afterwards) on rsp_word with rsp_valid high
// for exactly one cycle; the receiver must take it then, as there is no way
// to hold a response off. Busy drops in the cycle after the response.
//
// Timing. A request that fails its checks, or a one-element reverse,
// answers in the cycle after the accept; a back insert or back delete
// passes through S_READ and S_WRITE before it answers. Each entry moved by
// an insert or delete adds an S_READ and an S_WRITE, a search spends that
// pair on each entry compared and a reverse adds S_SWAP to it per swapped
// pair. The next word can be taken in the cycle after the response. The
// cost per entry is set by the store: one registered read and one write.
//
// Reset clears the element count and the sequencer; the store contents are
// not cleared, since only entries below the count are ever used.
module ordered_list_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ole_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output ole_pkg::rsp_word_type rsp_word
);
   import ole_pkg::*;

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_WRITE = 5'b00100,
      S_SWAP  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // The kind of walk a request needs once its checks have passed.
   typedef enum logic [1:0] {
      K_INS  = 2'd0,
      K_DEL  = 2'd1,
      K_SRCH = 2'd2,
      K_REV  = 2'd3
   } kind_type;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [COUNT_W-1:0]     lo_ff, lo_in;
   logic [COUNT_W-1:0]     hi_ff, hi_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [DATA_WIDTH-1:0]  value_ff, value_in;
   logic                   first_ff, first_in;
   status_type             status_ff, status_in;
   logic signed [31:0]     removed_ff, removed_in;
   logic [5:0]             found_ff, found_in;

   // The value store and its registered read data.
   logic [DATA_WIDTH-1:0]  store_mem [CAPACITY];
   logic [DATA_WIDTH-1:0]  rd_a_ff;
   logic [DATA_WIDTH-1:0]  rd_b_ff;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic [ADDR_W-1:0]      rd_addr_a;
   logic [ADDR_W-1:0]      rd_addr_b;

   logic [COUNT_W-1:0]     lo_inc;
   logic [COUNT_W-1:0]     hi_dec;
   logic [COUNT_W-1:0]     count_dec;
   logic [COUNT_W-1:0]     req_idx;

   assign lo_inc    = lo_ff + 1'b1;
   assign hi_dec    = hi_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign req_idx   = COUNT_W'(req_word.index);

   // Read addresses follow the walk: an insert pulls the entry below the
   // cursor, a delete the entry at and above it, a reverse both ends.
   always_comb begin
      rd_addr_a = lo_ff[ADDR_W-1:0];
      rd_addr_b = lo_inc[ADDR_W-1:0];
      case (kind_ff)
         K_INS: begin
            rd_addr_a = hi_dec[ADDR_W-1:0];
         end
         K_REV: begin
            rd_addr_b = hi_ff[ADDR_W-1:0];
         end
         default: begin
            rd_addr_a = lo_ff[ADDR_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_mem[rd_addr_a];
      rd_b_ff <= store_mem[rd_addr_b];
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      count_in   = count_ff;
      value_in   = value_ff;
      first_in   = first_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      wr_en      = 1'b0;
      wr_addr    = lo_ff[ADDR_W-1:0];
      wr_data    = rd_b_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Checks that end a request at once go straight to the
               // response; the rest set up a walk.
               value_in   = req_word.value[DATA_WIDTH-1:0];
               status_in  = ST_OK;
               removed_in = '0;
               found_in   = '0;
               first_in   = 1'b1;
               lo_in      = '0;
               hi_in      = count_ff;
               state_in   = S_DONE;
               case (req_word.operation)
                  OP_INS_IDX: begin
                     if (req_idx > count_ff) begin
                        status_in = ST_BAD_INDEX;
                     end else if (count_ff >= CAP_COUNT) begin
                        status_in = ST_FULL;
                     end else begin
                        kind_in  = K_INS;
                        lo_in    = req_idx;
                        state_in = S_READ;
                     end
                  end
                  OP_INS_FRONT, OP_INS_BACK: begin
                     if (count_ff >= CAP_COUNT) begin
                        status_in = ST_FULL;
                     end else begin
                        kind_in  = K_INS;
                        lo_in    = (req_word.operation == OP_INS_FRONT) ? '0 : count_ff;
                        state_in = S_READ;
                     end
                  end
                  OP_DEL_IDX: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (req_idx >= count_ff) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        kind_in  = K_DEL;
                        lo_in    = req_idx;
                        state_in = S_READ;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        kind_in  = K_DEL;
                        lo_in    = (req_word.operation == OP_DEL_FRONT) ? '0 : count_dec;
                        state_in = S_READ;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        kind_in  = K_SRCH;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     // Reverse; a single element stays as it is.
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (count_ff != COUNT_W'(1)) begin
                        kind_in  = K_REV;
                        hi_in    = count_dec;
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_WRITE;
         end

         S_WRITE: begin
            case (kind_ff)
               K_INS: begin
                  wr_en = 1'b1;
                  if (hi_ff == lo_ff) begin
                     // The gap has reached the target position.
                     wr_addr  = lo_ff[ADDR_W-1:0];
                     wr_data  = value_ff;
                     count_in = count_ff + 1'b1;
                     state_in = S_DONE;
                  end else begin
                     wr_addr  = hi_ff[ADDR_W-1:0];
                     wr_data  = rd_a_ff;
                     hi_in    = hi_dec;
                     state_in = S_READ;
                  end
               end
               K_DEL: begin
                  first_in = 1'b0;
                  if (first_ff) begin
                     removed_in = 32'($signed(rd_a_ff));
                  end
                  if (lo_inc < count_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = lo_ff[ADDR_W-1:0];
                     wr_data  = rd_b_ff;
                     lo_in    = lo_inc;
                     state_in = S_READ;
                  end else begin
                     count_in = count_dec;
                     state_in = S_DONE;
                  end
               end
               K_SRCH: begin
                  if (rd_a_ff == value_ff) begin
                     found_in = 6'(lo_ff);
                     state_in = S_DONE;
                  end else if (lo_inc == count_ff) begin
                     status_in = ST_MISS;
                     state_in  = S_DONE;
                  end else begin
                     lo_in    = lo_inc;
                     state_in = S_READ;
                  end
               end
               default: begin
                  // Reverse: the high entry goes to the low end first.
                  wr_en    = 1'b1;
                  wr_addr  = lo_ff[ADDR_W-1:0];
                  wr_data  = rd_b_ff;
                  state_in = S_SWAP;
               end
            endcase
         end

         S_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff[ADDR_W-1:0];
            wr_data  = rd_a_ff;
            lo_in    = lo_inc;
            hi_in    = hi_dec;
            state_in = (lo_inc < hi_dec) ? S_READ : S_DONE;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      kind_ff    <= kind_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      value_ff   <= value_in;
      first_ff   <= first_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
   end

   assign busy                    = (state_ff != S_IDLE);
   assign rsp_valid               = (state_ff == S_DONE);
   assign rsp_word.status         = status_ff;
   assign rsp_word.removed_value  = removed_ff;
   assign rsp_word.found_position = found_ff;
   assign rsp_word.element_total  = 7'(count_ff);

endmodule

@@ rtl/ole_checker.sv @@
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on ole_pkg and ordered_list_engine_assert.svh.
`include "ordered_list_engine_assert.svh"

module ole_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input ole_pkg::rsp_word_type rsp_word
);
   import ole_pkg::*;

   logic total_ok;
   logic failed_rsp;
   logic data_zero;

   assign total_ok   = (rsp_word.element_total <= 7'(CAPACITY));
   assign failed_rsp = rsp_valid && (rsp_word.status != ST_OK);
   assign data_zero  = (rsp_word.removed_value == '0) && (rsp_word.found_position == '0);

   `OLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `OLE_ASSERT_NOW(a_rsp_in_busy, rsp_valid, busy, "response shown while idle")
   `OLE_ASSERT_NEXT(a_rsp_once, rsp_valid, !busy && !rsp_valid, "response not followed by idle")
   `OLE_ASSERT_NOW(a_total_cap, rsp_valid, total_ok, "count over capacity")
   `OLE_ASSERT_NOW(a_err_zero, failed_rsp, data_zero, "failed request carries data")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);
